// ----- rtl/srrw_pkg.sv -----
package srrw_pkg;

   localparam int SEQ_W      = 32;
   localparam int DATA_W     = 32;
   localparam int SIZE_W     = 7;
   localparam int STATUS_W   = 2;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_FIELD_W = SEQ_W + SEQ_W + DATA_W + STATUS_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int DEF_WINDOW_DEPTH = 64;
   localparam int DEF_PAYLOAD_BITS = 32;

   localparam logic [SIZE_W-1:0] RESET_WINDOW_SIZE = 7'd64;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED    = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_STALE     = 2'd2
   } status_type;

   localparam logic ACT_DATA     = 1'b0;
   localparam logic ACT_TICK     = 1'b1;
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

endpackage

// ----- rtl/selective_repeat_receive_window_core.sv -----
// pipeline: a transfer's slot is read into stage 1, then stage 1 updates the slot and
//   registers the result, which raises rsp_tvalid; a held output stalls stage 1
// throughput: one data packet per cycle while the output is not held; after a service
//   tick the next transfer waits until the tick leaves stage 1 and head and start move
// reset: synchronous, active high; window start, head and window size reload, then a
//   clearing pass empties every slot of the slot memory before the first transfer
module selective_repeat_receive_window_core #(
   parameter int WINDOW_DEPTH = srrw_pkg::DEF_WINDOW_DEPTH,
   parameter int PAYLOAD_BITS = srrw_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [srrw_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srrw_pkg::REQ_TDATA_W-1:0]    req_tdata,   // seq_number, payload
   input  logic                                req_tuser,   // action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srrw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // ack_number, window_base,
                                                            // delivered_payload, arrival_status
   output logic                                rsp_tuser    // result_kind
);
   import srrw_pkg::*;

   localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int STORE_BITS = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
   localparam int ENTRY_W    = STORE_BITS + 1;
   localparam int RSP_PAD    = RSP_TDATA_W - RSP_FIELD_W;

   // slot memory: valid bit on top of the payload
   logic [ENTRY_W-1:0] slot_mem [WINDOW_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [SIZE_W-1:0]  size_ff;
   logic [SEQ_W-1:0]   start_ff, start_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic               clearing_ff;
   logic [IDX_W-1:0]   clr_ff;

   logic               s1_valid_ff, s1_tick_ff, s1_drop_ff, s1_below_ff;
   logic [SEQ_W-1:0]   s1_seq_ff;
   logic [STORE_BITS-1:0] s1_payload_ff;
   logic [IDX_W-1:0]   s1_addr_ff;
   logic               fwd_ff;
   logic [ENTRY_W-1:0] fwd_entry_ff;

   logic               rsp_valid_ff, rsp_kind_ff;
   logic [SEQ_W-1:0]   rsp_ack_ff, rsp_base_ff;
   logic [DATA_W-1:0]  rsp_payload_ff;
   status_type         rsp_status_ff;

   // stage 0: classify and form the slot address
   logic               req_accept;
   logic [SEQ_W-1:0]   req_seq;
   logic [SIZE_W-1:0]  eff_size;
   logic [SEQ_W:0]     limit;
   logic               drop0, below0;
   logic [SEQ_W-1:0]   diff;
   logic [IDX_W:0]     sum;
   logic [IDX_W:0]     slot_wide;
   logic [IDX_W-1:0]   rd_addr;

   assign req_seq  = req_tdata[SEQ_W-1:0];
   assign eff_size = (32'(size_ff) > WINDOW_DEPTH) ? SIZE_W'(WINDOW_DEPTH) : size_ff;
   assign limit    = {1'b0, start_ff} + (SEQ_W+1)'(eff_size);
   assign drop0    = {1'b0, req_seq} >= limit;
   assign below0   = req_seq < start_ff;
   assign diff     = req_seq - start_ff;
   assign sum      = {1'b0, head_ff} + {1'b0, diff[IDX_W-1:0]};
   assign slot_wide = (sum >= (IDX_W+1)'(WINDOW_DEPTH)) ?
                      sum - (IDX_W+1)'(WINDOW_DEPTH) : sum;
   assign rd_addr  = (req_tuser == ACT_TICK) ? head_ff : slot_wide[IDX_W-1:0];

   // stage 1: decide, write back, form the result
   logic [ENTRY_W-1:0] entry;
   logic               entry_valid;
   logic               s1_out, s1_fire, wr_item, wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   status_type         s1_status;

   assign entry       = fwd_ff ? fwd_entry_ff : rd_ff;
   assign entry_valid = entry[STORE_BITS];
   assign s1_out      = s1_valid_ff && (s1_tick_ff ? entry_valid : !s1_drop_ff);
   assign s1_fire     = s1_valid_ff && (!s1_out || !rsp_valid_ff || rsp_tready);
   assign wr_item     = s1_fire && (s1_tick_ff ? entry_valid
                                   : (!s1_drop_ff && !s1_below_ff && !entry_valid));
   assign wr_en       = wr_item || clearing_ff;
   assign wr_addr     = clearing_ff ? clr_ff : s1_addr_ff;
   assign wr_data     = (clearing_ff || s1_tick_ff) ? '0 : {1'b1, s1_payload_ff};

   always_comb begin
      if (s1_below_ff) begin
         s1_status = ST_STALE;
      end else if (entry_valid) begin
         s1_status = ST_DUPLICATE;
      end else begin
         s1_status = ST_STORED;
      end
   end

   assign req_tready = !clearing_ff && (!s1_valid_ff || (s1_fire && !s1_tick_ff));
   assign req_accept = req_tvalid && req_tready;

   assign start_in = start_ff + SEQ_W'(1);
   assign head_in  = (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (req_accept) begin
         rd_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= RESET_WINDOW_SIZE;
         start_ff    <= '0;
         head_ff     <= '0;
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (clearing_ff) begin
            if (clr_ff == IDX_W'(WINDOW_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end else begin
               clr_ff <= clr_ff + IDX_W'(1);
            end
         end
         if (wr_item && s1_tick_ff) begin
            start_ff <= start_in;
            head_ff  <= head_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire && s1_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_tick_ff    <= (req_tuser == ACT_TICK);
         s1_drop_ff    <= drop0;
         s1_below_ff   <= below0;
         s1_seq_ff     <= req_seq;
         s1_payload_ff <= req_tdata[SEQ_W +: STORE_BITS];
         s1_addr_ff    <= rd_addr;
         fwd_ff        <= wr_item && (s1_addr_ff == rd_addr);
         fwd_entry_ff  <= wr_data;
      end
      if (s1_fire && s1_out) begin
         rsp_kind_ff    <= s1_tick_ff ? KIND_DELIVER : KIND_ACK;
         rsp_ack_ff     <= s1_tick_ff ? start_ff : s1_seq_ff;
         rsp_base_ff    <= start_ff;
         rsp_payload_ff <= s1_tick_ff ? DATA_W'(entry[STORE_BITS-1:0]) : '0;
         rsp_status_ff  <= s1_tick_ff ? ST_STORED : s1_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_status_ff, rsp_payload_ff, rsp_base_ff, rsp_ack_ff};

`ifndef NO_ASSERTIONS
   a_start_step: assert property (@(posedge clock) disable iff (reset)
      start_ff != $past(start_ff) |-> start_ff == $past(start_ff) + SEQ_W'(1))
      else $error("window start moved by more than one");

   a_head_follows: assert property (@(posedge clock) disable iff (reset)
      start_ff != $past(start_ff) |-> head_ff == $past(head_in))
      else $error("head slot out of step with window start");

   a_no_item_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("item in flight during clearing pass");

   a_tick_interlock: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_tick_ff |-> !req_tready)
      else $error("transfer taken behind a pending service tick");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import srrw_pkg::*;

   localparam int DEPTH       = DEF_WINDOW_DEPTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 300;
   localparam int EXP_DEPTH   = 1024;

   typedef struct packed {
      logic          kind;
      logic [31:0]   number;
      logic [31:0]   base;
      logic [31:0]   data;
      status_type    status;
   } rx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0]       csr_wr_data = '0;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata   = '0;
   logic                    req_tuser   = ACT_DATA;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;

   // predicted receive window
   bit                slot_full [DEPTH];
   logic [31:0]       slot_data [DEPTH];
   logic [31:0]       win_start = '0;
   logic [5:0]        head = '0;
   logic [SIZE_W-1:0] win_size = RESET_WINDOW_SIZE;

   // ring of expected results
   rx_result_type exp_mem [EXP_DEPTH];
   logic [9:0]    exp_wr = '0;
   logic [9:0]    exp_rd = '0;
   int unsigned mismatches = 0;
   int unsigned transfers = 0, stored = 0, duplicates = 0, stale = 0, delivered = 0;
   int unsigned cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_start = 1'b0;
   bit          no_idle = 1'b0;
   bit          last_hit;

   function automatic logic [9:0] pending();
      return exp_wr - exp_rd;
   endfunction

   selective_repeat_receive_window_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 17);
      end
   end

   function automatic bit window_step(input logic act, input logic [31:0] seq,
                                      input logic [31:0] pay, output rx_result_type r);
      logic [32:0] limit;
      logic [5:0]  idx;
      int unsigned eff;
      eff = (win_size > DEPTH) ? DEPTH : win_size;
      r = '{kind: KIND_ACK, number: seq, base: win_start, data: '0, status: ST_STORED};
      if (act == ACT_TICK) begin
         if (!slot_full[head]) return 1'b0;
         r.kind   = KIND_DELIVER;
         r.number = win_start;
         r.data   = slot_data[head];
         slot_full[head] = 1'b0;
         head      = head + 6'd1;
         win_start = win_start + 32'd1;
         delivered++;
         return 1'b1;
      end
      limit = {1'b0, win_start} + 33'(eff);
      if ({1'b0, seq} >= limit) return 1'b0;
      if (seq < win_start) begin
         r.status = ST_STALE;
         stale++;
         return 1'b1;
      end
      idx = head + 6'(seq - win_start);
      if (slot_full[idx]) begin
         r.status = ST_DUPLICATE;
         duplicates++;
      end else begin
         slot_full[idx] = 1'b1;
         slot_data[idx] = pay;
         stored++;
      end
      return 1'b1;
   endfunction

   task automatic send_item(input logic act, input logic [31:0] seq, input logic [31:0] pay);
      rx_result_type r;
      while (!no_idle && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {pay, seq};
      do @(posedge clock); while (!req_tready);
      transfers++;
      last_hit = window_step(act, seq, pay, r);
      if (last_hit) begin
         exp_mem[exp_wr] = r;
         exp_wr = exp_wr + 10'd1;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending() != 10'd0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_window(input logic [SIZE_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_size = value;
   endtask

   always @(posedge clock) begin : rsp_check
      rx_result_type got, want;
      logic          pad_bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind   = rsp_tuser;
         got.number = rsp_tdata[31:0];
         got.base   = rsp_tdata[63:32];
         got.data   = rsp_tdata[95:64];
         got.status = status_type'(rsp_tdata[97:96]);
         pad_bad    = |rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W];
         if (pending() == 10'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result kind=%0b num=%h base=%h data=%h st=%0d",
                        $realtime, got.kind, got.number, got.base, got.data, got.status);
         end else begin
            want   = exp_mem[exp_rd];
            exp_rd = exp_rd + 10'd1;
            if (got != want || pad_bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp kind=%0b num=%h base=%h data=%h st=%0d",
                           $realtime, want.kind, want.number, want.base, want.data,
                           want.status);
                  $display("           got kind=%0b num=%h base=%h data=%h st=%0d pad=%0b",
                           got.kind, got.number, got.base, got.data, got.status, pad_bad);
               end
            end
         end
      end
   end

   task automatic test_basic_arrivals();
      send_item(ACT_DATA, 32'd0, 32'hFFFF_FFFF);
      send_item(ACT_DATA, 32'd0, 32'h0);
      send_item(ACT_DATA, 32'd63, 32'h0);
      send_item(ACT_DATA, 32'd64, 32'h1);
      send_item(ACT_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_TICK, 32'hFFFF_FFFF, 32'h0);
      send_item(ACT_TICK, 32'h0, 32'hFFFF_FFFF);
      send_item(ACT_DATA, 32'd0, 32'h1234_5678);
      send_item(ACT_DATA, 32'd1, 32'h5A5A_5A5A);
      send_item(ACT_TICK, 32'h0, 32'h0);
   endtask

   task automatic test_window_extremes();
      write_window(7'd0);
      send_item(ACT_DATA, win_start, 32'hA5A5_A5A5);
      send_item(ACT_TICK, 32'h0, 32'h0);
      write_window(7'd1);
      send_item(ACT_DATA, win_start + 32'd1, 32'h1);
      send_item(ACT_DATA, win_start, 32'hC3C3_C3C3);
      send_item(ACT_TICK, 32'h0, 32'h0);
      write_window(7'd127);
      send_item(ACT_DATA, win_start + 32'd63, 32'h8000_0001);
      send_item(ACT_DATA, win_start + 32'd64, 32'h2);
      write_window(7'd65);
      send_item(ACT_DATA, win_start + 32'd63, 32'h3);
   endtask

   task automatic test_window_shrink();
      write_window(7'd64);
      for (int i = 0; i < 4; i++) send_item(ACT_DATA, win_start + 32'(i), $urandom);
      write_window(7'd2);
      send_item(ACT_DATA, win_start + 32'd3, 32'h4);
      repeat (5) send_item(ACT_TICK, $urandom, $urandom);
   endtask

   task automatic random_traffic(input int unsigned want);
      int unsigned hits, tries, eff, pick;
      logic        act;
      logic [31:0] seq;
      hits  = 0;
      tries = 0;
      while (hits < want && tries < want * 4) begin
         eff  = (win_size > DEPTH) ? DEPTH : win_size;
         pick = $urandom_range(99);
         if (pick < 8) begin
            act = logic'($urandom_range(1));
            seq = $urandom;
         end else if (pick < 38) begin
            act = ACT_TICK;
            seq = $urandom;
         end else begin
            act = ACT_DATA;
            seq = win_start + 32'($urandom_range(eff + 5)) - 32'd4;
         end
         send_item(act, seq, $urandom);
         tries++;
         if (last_hit) hits++;
      end
   endtask

   task automatic test_backpressure();
      settle();
      no_idle    = 1'b1;
      hold_start = 1'b1;
      random_traffic(150);
      no_idle = 1'b0;
      settle();
   endtask

   initial begin
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_basic_arrivals();
      test_window_extremes();
      test_window_shrink();
      write_window(7'd64);
      random_traffic(300);
      write_window(7'd1);
      random_traffic(100);
      write_window(7'd0);
      random_traffic(30);
      write_window(7'd127);
      no_idle = 1'b1;
      random_traffic(150);
      no_idle = 1'b0;
      test_backpressure();
      repeat (4) begin
         write_window(SIZE_W'($urandom_range(1, 127)));
         random_traffic(100);
      end
      write_window(7'd9);
      random_traffic(150);
      settle();
      $display("%0d transfers in %0d cycles: %0d stored, %0d duplicate, %0d stale, %0d delivered",
               transfers, cycles, stored, duplicates, stale, delivered);
      $display("window sizes 0 to 127 incl. a run-time shrink, long receiver hold, %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending() == 10'd0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
